/* hdl/mtep_pkg.sv */
// Types and constants shared by the MIDI track event parser files.
package mtep_pkg;

   localparam logic [1:0] KIND_CHANNEL   = 2'd0;
   localparam logic [1:0] KIND_TEMPO     = 2'd1;
   localparam logic [1:0] KIND_DONE      = 2'd2;
   localparam logic [1:0] KIND_NO_STATUS = 2'd3;

   localparam logic [7:0] STATUS_SYSTEM   = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_CT = 8'hF7;
   localparam logic [7:0] STATUS_META     = 8'hFF;
   localparam logic [7:0] ONE_DATA_LO     = 8'hC0;
   localparam logic [7:0] ONE_DATA_HI     = 8'hDF;
   localparam logic [7:0] META_TEMPO      = 8'h51;
   localparam logic [7:0] SKIP_MARK       = 8'hFF;

   localparam int QTY_W    = 28;
   localparam int GROUPS_W = 3;
   localparam logic [GROUPS_W-1:0] VLQ_MAX_GROUPS = 3'd4;
   localparam logic [1:0] TEMPO_BYTES = 2'd3;

   typedef struct packed {
      logic       track_end;
      logic [7:0] data_byte;
   } mtep_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] delta_ticks;
      logic [31:0] event_time;
      logic [7:0]  status_byte;
      logic        running_used;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [23:0] tempo_value;
      logic        truncated;
   } mtep_rsp_type;

   function automatic logic one_data(input logic [7:0] status);
      return (status >= ONE_DATA_LO) && (status <= ONE_DATA_HI);
   endfunction

endpackage

/* hdl/mtep_if.sv */
// Valid/ready channel interfaces for track bytes and parsed events.
interface mtep_req_if;
   import mtep_pkg::*;
   logic         valid;
   logic         ready;
   mtep_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mtep_rsp_if;
   import mtep_pkg::*;
   logic         valid;
   logic         ready;
   mtep_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hdl/midi_track_event_parser.sv */
// MIDI track event parser: one track byte per beat in, decoded events out.
// A byte accepted lands in the input register and is parsed from there into the
// result register, where its event waits until the sink takes it.
// Throughput: one byte per cycle, set by the single-pass parse step, while the result register is empty or taken.
// Reset (synchronous, active high) empties both registers and clears all
// parse state; a track-end beat clears the parse state the same way.
module midi_track_event_parser (
   input logic clock,
   input logic reset,
   mtep_req_if.sink   req_bus,
   mtep_rsp_if.source rsp_bus
);
   import mtep_pkg::*;

   localparam logic [2:0] PH_DELTA   = 3'd0;
   localparam logic [2:0] PH_STATUS  = 3'd1;
   localparam logic [2:0] PH_DATA1   = 3'd2;
   localparam logic [2:0] PH_DATA2   = 3'd3;
   localparam logic [2:0] PH_UNKNOWN = 3'd4;
   localparam logic [2:0] PH_MTYPE   = 3'd5;
   localparam logic [2:0] PH_LENGTH  = 3'd6;
   localparam logic [2:0] PH_BODY    = 3'd7;

   logic         in_valid_ff;
   mtep_req_type in_data_ff;
   logic         out_valid_ff, out_valid_in;
   mtep_rsp_type out_data_ff, out_data_in;

   logic [2:0]          phase_ff, phase_in;
   logic [QTY_W-1:0]    qty_ff, qty_in;
   logic [GROUPS_W-1:0] groups_ff, groups_in;
   logic [31:0]         pend_ff, pend_in;
   logic [31:0]         abs_ff, abs_in;
   logic [7:0]          last_ff, last_in;
   logic                running_ff, running_in;
   logic [7:0]          held_ff, held_in;
   logic [7:0]          meta_ff, meta_in;
   logic [QTY_W-1:0]    skip_ff, skip_in;
   logic [23:0]         tempo_ff, tempo_in;
   logic [1:0]          seen_ff, seen_in;

   logic                advance, process, has_rsp;
   logic [7:0]          b;
   logic [QTY_W-1:0]    qty_take;
   logic [GROUPS_W-1:0] groups_take;
   logic                qty_done;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign process       = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.payload = out_data_ff;

   assign b           = in_data_ff.data_byte;
   assign qty_take    = {qty_ff[QTY_W-8:0], b[6:0]};
   assign groups_take = groups_ff + 1'b1;
   assign qty_done    = !b[7] || (groups_take >= VLQ_MAX_GROUPS);

   always_comb begin
      phase_in   = phase_ff;
      qty_in     = qty_ff;
      groups_in  = groups_ff;
      pend_in    = pend_ff;
      abs_in     = abs_ff;
      last_in    = last_ff;
      running_in = running_ff;
      held_in    = held_ff;
      meta_in    = meta_ff;
      skip_in    = skip_ff;
      tempo_in   = tempo_ff;
      seen_in    = seen_ff;
      has_rsp    = 1'b0;
      out_data_in = '0;
      out_data_in.delta_ticks = pend_ff;
      out_data_in.event_time  = abs_ff;

      if (in_data_ff.track_end) begin
         has_rsp = 1'b1;
         out_data_in.kind      = KIND_DONE;
         out_data_in.truncated = (phase_ff != PH_DELTA) || (groups_ff != '0);
         phase_in   = PH_DELTA;
         qty_in     = '0;
         groups_in  = '0;
         pend_in    = '0;
         abs_in     = '0;
         last_in    = '0;
         running_in = 1'b0;
         held_in    = '0;
         meta_in    = '0;
         skip_in    = '0;
         tempo_in   = '0;
         seen_in    = '0;
      end else begin
         unique case (phase_ff)
            PH_DELTA: begin
               qty_in    = qty_take;
               groups_in = groups_take;
               if (qty_done) begin
                  pend_in   = pend_ff + {4'b0, qty_take};
                  abs_in    = abs_ff + {4'b0, qty_take};
                  qty_in    = '0;
                  groups_in = '0;
                  phase_in  = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (b[7]) begin
                  running_in = 1'b0;
                  if (b < STATUS_SYSTEM) begin
                     last_in  = b;
                     phase_in = PH_DATA1;
                  end else begin
                     // system statuses cancel running status
                     last_in = '0;
                     if (b == STATUS_META) begin
                        phase_in = PH_MTYPE;
                     end else if (b == STATUS_SYSEX || b == STATUS_SYSEX_CT) begin
                        meta_in  = SKIP_MARK;
                        phase_in = PH_LENGTH;
                     end else begin
                        meta_in  = SKIP_MARK;
                        phase_in = PH_UNKNOWN;
                     end
                  end
               end else if (last_ff == '0) begin
                  phase_in = PH_DELTA;
                  has_rsp  = 1'b1;
                  out_data_in.kind       = KIND_NO_STATUS;
                  out_data_in.first_data = b;
               end else begin
                  running_in = 1'b1;
                  held_in    = b;
                  if (one_data(last_ff)) begin
                     phase_in = PH_DELTA;
                     has_rsp  = 1'b1;
                     out_data_in.kind         = KIND_CHANNEL;
                     out_data_in.status_byte  = last_ff;
                     out_data_in.running_used = 1'b1;
                     out_data_in.first_data   = b;
                  end else begin
                     phase_in = PH_DATA2;
                  end
               end
            end
            PH_DATA1: begin
               held_in = b;
               if (one_data(last_ff)) begin
                  phase_in = PH_DELTA;
                  has_rsp  = 1'b1;
                  out_data_in.kind         = KIND_CHANNEL;
                  out_data_in.status_byte  = last_ff;
                  out_data_in.running_used = running_ff;
                  out_data_in.first_data   = b;
               end else begin
                  phase_in = PH_DATA2;
               end
            end
            PH_DATA2: begin
               phase_in = PH_DELTA;
               has_rsp  = 1'b1;
               out_data_in.kind         = KIND_CHANNEL;
               out_data_in.status_byte  = last_ff;
               out_data_in.running_used = running_ff;
               out_data_in.first_data   = held_ff;
               out_data_in.second_data  = b;
            end
            PH_UNKNOWN: begin
               phase_in = PH_DELTA;
            end
            PH_MTYPE: begin
               meta_in  = b;
               tempo_in = '0;
               seen_in  = '0;
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               qty_in    = qty_take;
               groups_in = groups_take;
               if (qty_done) begin
                  skip_in   = qty_take;
                  qty_in    = '0;
                  groups_in = '0;
                  if (qty_take == '0) begin
                     phase_in = PH_DELTA;
                     if (meta_ff == META_TEMPO) begin
                        has_rsp = 1'b1;
                        out_data_in.kind        = KIND_TEMPO;
                        out_data_in.status_byte = STATUS_META;
                        out_data_in.tempo_value = tempo_ff;
                     end
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               // shift in the first three body bytes of a tempo event
               if (meta_ff == META_TEMPO && seen_ff < TEMPO_BYTES) begin
                  tempo_in = {tempo_ff[15:0], b};
                  seen_in  = seen_ff + 1'b1;
               end
               skip_in = skip_ff - 1'b1;
               if (skip_in == '0) begin
                  phase_in = PH_DELTA;
                  if (meta_ff == META_TEMPO) begin
                     has_rsp = 1'b1;
                     out_data_in.kind        = KIND_TEMPO;
                     out_data_in.status_byte = STATUS_META;
                     out_data_in.tempo_value = tempo_in;
                  end
               end
            end
         endcase
      end

      // a reported event takes the pending delta with it
      if (has_rsp) begin
         pend_in = '0;
      end
   end

   always_comb begin
      if (process) begin
         out_valid_in = has_rsp;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_data_ff <= req_bus.payload;
      end
      if (process && has_rsp) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_DELTA;
         qty_ff       <= '0;
         groups_ff    <= '0;
         pend_ff      <= '0;
         abs_ff       <= '0;
         last_ff      <= '0;
         running_ff   <= 1'b0;
         held_ff      <= '0;
         meta_ff      <= '0;
         skip_ff      <= '0;
         tempo_ff     <= '0;
         seen_ff      <= '0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         out_valid_ff <= out_valid_in;
         if (process) begin
            phase_ff   <= phase_in;
            qty_ff     <= qty_in;
            groups_ff  <= groups_in;
            pend_ff    <= pend_in;
            abs_ff     <= abs_in;
            last_ff    <= last_in;
            running_ff <= running_in;
            held_ff    <= held_in;
            meta_ff    <= meta_in;
            skip_ff    <= skip_in;
            tempo_ff   <= tempo_in;
            seen_ff    <= seen_in;
         end
      end
   end

endmodule

/* hdl/mtep_checker.sv */
// Port-level checks for the MIDI track event parser, bound to the top level.
module mtep_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input mtep_pkg::mtep_rsp_type rsp_data
);
   import mtep_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_DONE |->
         rsp_data.status_byte == '0 && rsp_data.first_data == '0 &&
         rsp_data.second_data == '0 && rsp_data.tempo_value == '0)
      else $error("track done beat carries event fields");

   a_tempo_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_TEMPO |->
         rsp_data.status_byte == STATUS_META && !rsp_data.running_used &&
         rsp_data.first_data == '0 && rsp_data.second_data == '0)
      else $error("tempo beat with bad fields");

   a_truncated_done_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_DONE |-> !rsp_data.truncated &&
         (rsp_data.kind == KIND_CHANNEL || rsp_data.tempo_value == '0 ||
          rsp_data.kind == KIND_TEMPO))
      else $error("truncated flag or tempo value on wrong kind");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.payload)
);

/* tb/midi_track_event_parser_tb.sv */
// Self-checking testbench for the MIDI track event parser: predicts each event and compares.
`timescale 1ns / 100ps

module midi_track_event_parser_tb;
   import mtep_pkg::*;

   localparam int PLAN_BEATS     = 1530;
   localparam int HOLD_OFF_AT    = 150;
   localparam int HOLD_OFF_BEATS = 400;
   localparam int SETTLE_CYCLES  = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [3:0] {
      AWAIT_DELTA, AWAIT_STATUS, AWAIT_DATA1, AWAIT_DATA2,
      SKIP_ONE, AWAIT_META_TYPE, AWAIT_LENGTH, SKIP_BODY
   } parse_phase_type;

   typedef enum {PACE_FULL, PACE_COIN, PACE_SPARSE, PACE_THIRD} rsp_pace_type;

   typedef struct {
      bit           wait_for_drain;
      mtep_req_type beat;
   } planned_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mtep_req_if req_bus ();
   mtep_rsp_if rsp_bus ();

   midi_track_event_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   planned_beat_type pending_beats[$];
   mtep_rsp_type     awaited_events[$];
   int               error_count = 0;
   int               events_seen = 0;
   int               idle_cycles = 0;

   // stimulus generator state
   logic [7:0] plan_status = 8'h00;
   bit         drain_next  = 1'b0;

   // predictor state
   parse_phase_type phase;
   logic [27:0]  qty_acc;
   logic [2:0]   qty_groups;
   logic [31:0]  delta_due;
   logic [31:0]  track_time;
   logic [7:0]   status_held;
   logic         running_seen;
   logic [7:0]   data_held;
   logic [7:0]   meta_type;
   logic [27:0]  body_left;
   logic [23:0]  tempo_acc;
   logic [1:0]   tempo_count;

   function automatic bit is_one_data(input logic [7:0] status);
      return status >= ONE_DATA_LO && status <= ONE_DATA_HI;
   endfunction

   task automatic clear_parse();
      phase        = AWAIT_DELTA;
      qty_acc      = '0;
      qty_groups   = '0;
      delta_due    = '0;
      track_time   = '0;
      status_held  = '0;
      running_seen = 1'b0;
      data_held    = '0;
      meta_type    = '0;
      body_left    = '0;
      tempo_acc    = '0;
      tempo_count  = '0;
   endtask

   task automatic push_event(input logic [1:0] kind, input logic [7:0] status,
                             input logic running, input logic [7:0] d1,
                             input logic [7:0] d2, input logic [23:0] tempo,
                             input logic trunc);
      mtep_rsp_type ev;
      ev.kind         = kind;
      ev.delta_ticks  = delta_due;
      ev.event_time   = track_time;
      ev.status_byte  = status;
      ev.running_used = running;
      ev.first_data   = d1;
      ev.second_data  = d2;
      ev.tempo_value  = tempo;
      ev.truncated    = trunc;
      awaited_events.push_back(ev);
      delta_due = '0;
   endtask

   // shift in one 7-bit group; the fourth group always closes the quantity
   function automatic bit take_group(input logic [7:0] b);
      qty_acc    = {qty_acc[20:0], b[6:0]};
      qty_groups = qty_groups + 3'd1;
      return !b[7] || qty_groups >= VLQ_MAX_GROUPS;
   endfunction

   task automatic finish_meta();
      phase = AWAIT_DELTA;
      if (meta_type == META_TEMPO)
         push_event(KIND_TEMPO, STATUS_META, 1'b0, 8'h00, 8'h00, tempo_acc, 1'b0);
   endtask

   task automatic parse_track_byte(input mtep_req_type beat);
      logic [7:0] b;
      b = beat.data_byte;
      if (beat.track_end) begin
         push_event(KIND_DONE, 8'h00, 1'b0, 8'h00, 8'h00, 24'h0,
                    phase != AWAIT_DELTA || qty_groups != 0);
         clear_parse();
      end else begin
         case (phase)
            AWAIT_DELTA: begin
               if (take_group(b)) begin
                  delta_due  = delta_due + {4'h0, qty_acc};
                  track_time = track_time + {4'h0, qty_acc};
                  qty_acc    = '0;
                  qty_groups = '0;
                  phase      = AWAIT_STATUS;
               end
            end
            AWAIT_STATUS: begin
               if (b[7]) begin
                  running_seen = 1'b0;
                  if (b < STATUS_SYSTEM) begin
                     status_held = b;
                     phase       = AWAIT_DATA1;
                  end else begin
                     // any system status cancels running status
                     status_held = 8'h00;
                     if (b == STATUS_META) begin
                        phase = AWAIT_META_TYPE;
                     end else if (b == STATUS_SYSEX || b == STATUS_SYSEX_CT) begin
                        meta_type = SKIP_MARK;
                        phase     = AWAIT_LENGTH;
                     end else begin
                        meta_type = SKIP_MARK;
                        phase     = SKIP_ONE;
                     end
                  end
               end else if (status_held == 8'h00) begin
                  phase = AWAIT_DELTA;
                  push_event(KIND_NO_STATUS, 8'h00, 1'b0, b, 8'h00, 24'h0, 1'b0);
               end else begin
                  running_seen = 1'b1;
                  data_held    = b;
                  if (is_one_data(status_held)) begin
                     phase = AWAIT_DELTA;
                     push_event(KIND_CHANNEL, status_held, 1'b1, b, 8'h00, 24'h0, 1'b0);
                  end else begin
                     phase = AWAIT_DATA2;
                  end
               end
            end
            AWAIT_DATA1: begin
               data_held = b;
               if (is_one_data(status_held)) begin
                  phase = AWAIT_DELTA;
                  push_event(KIND_CHANNEL, status_held, running_seen, b, 8'h00, 24'h0, 1'b0);
               end else begin
                  phase = AWAIT_DATA2;
               end
            end
            AWAIT_DATA2: begin
               phase = AWAIT_DELTA;
               push_event(KIND_CHANNEL, status_held, running_seen, data_held, b, 24'h0, 1'b0);
            end
            SKIP_ONE: phase = AWAIT_DELTA;
            AWAIT_META_TYPE: begin
               meta_type   = b;
               tempo_acc   = '0;
               tempo_count = '0;
               phase       = AWAIT_LENGTH;
            end
            AWAIT_LENGTH: begin
               if (take_group(b)) begin
                  body_left  = qty_acc;
                  qty_acc    = '0;
                  qty_groups = '0;
                  if (body_left == 0)
                     finish_meta();
                  else
                     phase = SKIP_BODY;
               end
            end
            SKIP_BODY: begin
               if (meta_type == META_TEMPO && tempo_count < TEMPO_BYTES) begin
                  tempo_acc   = {tempo_acc[15:0], b};
                  tempo_count = tempo_count + 2'd1;
               end
               body_left = body_left - 28'd1;
               if (body_left == 0)
                  finish_meta();
            end
            default: phase = AWAIT_DELTA;
         endcase
      end
   endtask

   // ---------------- stimulus plan ----------------

   task automatic add_byte(input logic [7:0] b);
      planned_beat_type p;
      p.wait_for_drain = drain_next;
      p.beat           = {1'b0, b};
      pending_beats.push_back(p);
      drain_next = 1'b0;
   endtask

   task automatic add_end();
      planned_beat_type p;
      p.wait_for_drain = drain_next;
      p.beat           = {1'b1, 8'($urandom_range(0, 255))};
      pending_beats.push_back(p);
      drain_next = 1'b0;
   endtask

   task automatic add_data();
      if ($urandom_range(0, 7) == 0)
         add_byte(8'($urandom_range(0, 255)));
      else
         add_byte(8'($urandom_range(0, 127)));
   endtask

   task automatic add_delta();
      int pick;
      int groups;
      pick   = $urandom_range(0, 9);
      groups = (pick < 6) ? 1 : (pick < 8) ? 2 : (pick < 9) ? 3 : 4;
      if (pick < 3) begin
         add_byte(8'h00);
      end else begin
         for (int i = 1; i < groups; i++)
            add_byte(8'h80 | 8'($urandom_range(0, 127)));
         // a fourth group may keep its top bit set
         if (groups == 4 && $urandom_range(0, 1) == 1)
            add_byte(8'h80 | 8'($urandom_range(0, 127)));
         else
            add_byte(8'($urandom_range(0, 127)));
      end
   endtask

   // length as a quantity, padded with empty leading groups up to four
   task automatic add_length(input int len);
      int groups;
      int pad;
      groups = (len > 127) ? 2 : 1;
      pad    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4 - groups) : 0;
      repeat (pad) add_byte(8'h80);
      if (groups == 2)
         add_byte(8'h80 | 8'(len >> 7));
      if (pad + groups == 4 && $urandom_range(0, 1) == 1)
         add_byte(8'h80 | (8'(len) & 8'h7F));
      else
         add_byte(8'(len) & 8'h7F);
   endtask

   task automatic add_skip_body();
      int len;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 6);
      add_length(len);
      repeat (len) add_byte(8'($urandom_range(0, 255)));
      plan_status = 8'h00;
   endtask

   task automatic add_track();
      int         pick;
      int         len;
      logic [7:0] st;
      plan_status = 8'h00;
      if ($urandom_range(0, 5) == 0)
         drain_next = 1'b1;
      repeat ($urandom_range(1, 14)) begin
         add_delta();
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            add_byte(st);
            add_data();
            if (!is_one_data(st))
               add_data();
            plan_status = st;
         end else if (pick < 55) begin
            // running status, or data with no status when none is in force
            add_byte(8'($urandom_range(0, 127)));
            if (plan_status != 8'h00 && !is_one_data(plan_status))
               add_data();
         end else if (pick < 67) begin
            add_byte(STATUS_META);
            add_byte(META_TEMPO);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 3;
            add_length(len);
            repeat (len) add_byte(8'($urandom_range(0, 255)));
            plan_status = 8'h00;
         end else if (pick < 77) begin
            add_byte(STATUS_META);
            add_byte(8'($urandom_range(0, 255)));
            add_skip_body();
         end else if (pick < 87) begin
            add_byte(($urandom_range(0, 1) == 1) ? STATUS_SYSEX : STATUS_SYSEX_CT);
            add_skip_body();
         end else if (pick < 94) begin
            st = 8'($urandom_range(8'hF1, 8'hFD));
            if (st >= STATUS_SYSEX_CT)
               st = st + 8'd1;
            add_byte(st);
            add_byte(8'($urandom_range(0, 255)));
            plan_status = 8'h00;
         end else begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
         end
      end
      // sometimes cut the track inside a delta or inside an event
      case ($urandom_range(0, 9))
         0: add_byte(8'h81);
         1: begin
            add_byte(8'h00);
            add_byte(8'h90);
         end
         default: ;
      endcase
      add_end();
   endtask

   // ---------------- driver ----------------

   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_beats
      logic             offer;
      mtep_req_type     next_beat;
      planned_beat_type p;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.payload <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         offer     = req_bus.valid;
         next_beat = req_bus.payload;
         if (req_bus.valid && req_bus.ready) begin
            parse_track_byte(req_bus.payload);
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_beats.size() != 0 &&
                         !(pending_beats[0].wait_for_drain && awaited_events.size() != 0)) begin
               p         = pending_beats.pop_front();
               next_beat = p.beat;
               offer     = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 30);
                  gap_left   = $urandom_range(1, 15);
               end else begin
                  burst_left--;
               end
            end
         end
         req_bus.valid   <= offer;
         req_bus.payload <= next_beat;
      end
   end

   // ---------------- monitor ----------------

   rsp_pace_type pace      = PACE_FULL;
   int           pace_left = 0;
   int           pace_tick = 0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;

   function automatic string event_text(input mtep_rsp_type e);
      return {$sformatf("kind %0d delta %0d time %0d status %02h run %0d data %02h %02h",
                        e.kind, e.delta_ticks, e.event_time, e.status_byte,
                        e.running_used, e.first_data, e.second_data),
              $sformatf(" tempo %0d trunc %0d", e.tempo_value, e.truncated)};
   endfunction

   task automatic log_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t: %s", $time, msg);
   endtask

   task automatic check_event(input mtep_rsp_type got);
      mtep_rsp_type want;
      string        diff;
      events_seen++;
      if (awaited_events.size() == 0) begin
         log_failure({"event with nothing awaited: ", event_text(got)});
      end else begin
         want = awaited_events.pop_front();
         diff = "";
         if (got.kind !== want.kind)                 diff = {diff, " kind"};
         if (got.delta_ticks !== want.delta_ticks)   diff = {diff, " delta_ticks"};
         if (got.event_time !== want.event_time)     diff = {diff, " event_time"};
         if (got.status_byte !== want.status_byte)   diff = {diff, " status_byte"};
         if (got.running_used !== want.running_used) diff = {diff, " running_used"};
         if (got.first_data !== want.first_data)     diff = {diff, " first_data"};
         if (got.second_data !== want.second_data)   diff = {diff, " second_data"};
         if (got.tempo_value !== want.tempo_value)   diff = {diff, " tempo_value"};
         if (got.truncated !== want.truncated)       diff = {diff, " truncated"};
         if (diff != "")
            log_failure($sformatf("event %0d differs in%s\n   expected %s\n   actual   %s",
                                  events_seen, diff, event_text(want), event_text(got)));
      end
   endtask

   always @(posedge clock) begin : check_events
      logic next_ready;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_event(rsp_bus.payload);
         // hold off once for a long stretch so the parser backs up
         if (!hold_done && events_seen >= HOLD_OFF_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_BEATS;
         end
         if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            if (pace_left == 0) begin
               pace      = rsp_pace_type'($urandom_range(0, 3));
               pace_left = $urandom_range(20, 200);
            end else begin
               pace_left--;
            end
            pace_tick++;
            case (pace)
               PACE_FULL:   next_ready = 1'b1;
               PACE_COIN:   next_ready = 1'($urandom_range(0, 1));
               PACE_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
               default:     next_ready = (pace_tick % 3 == 0);
            endcase
         end
         rsp_bus.ready <= next_ready;
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved in %0d cycles, %0d events awaited",
                  WATCHDOG_LIMIT, awaited_events.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- plan, reset and end of run ----------------

   initial begin
      logic [7:0] script[$];
      clear_parse();

      // two-byte note, running status, four-group delta with unknown status,
      // data with no status, full tempo, one-data status, sysex cut short
      script = '{8'h00, 8'h90, 8'h3C, 8'h7F,
                 8'h00, 8'h40, 8'h00,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF3, 8'h80,
                 8'h00, 8'h45,
                 8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                 8'h00, 8'hDF, 8'hFF,
                 8'h00, 8'hF0, 8'h05, 8'h01};
      foreach (script[i]) add_byte(script[i]);
      add_end();
      script = '{8'h00, 8'hC0, 8'h00};
      foreach (script[i]) add_byte(script[i]);
      add_end();

      drain_next = 1'b1;
      while (pending_beats.size() < PLAN_BEATS)
         add_track();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (pending_beats.size() != 0 || req_bus.valid || awaited_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* files.f */
hdl/mtep_pkg.sv
hdl/mtep_if.sv
hdl/midi_track_event_parser.sv
hdl/mtep_checker.sv
tb/midi_track_event_parser_tb.sv
